@@ src/lrp_pkg.sv @@
package lrp_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int AGE_W     = 4;
    localparam int CFG_W     = 4;
    localparam int FI_W      = 3;
    localparam int TOTAL_W   = 32;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(FRAMES);
    localparam logic             REG_FRAMES_IN_USE = 1'b0;

    typedef struct packed {
        logic                 valid;
        logic                 upd;
        logic [IDX_W-1:0]     pos;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [AGE_W-1:0]     hit_age;
        logic [AGE_W-1:0]     best_age;
        logic [IDX_W-1:0]     best_idx;
    } lrp_tok_t;

    function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? AGE_MAX : AGE_W'(a + 1'b1);
    endfunction

endpackage

@@ src/lru_page_replacement_core.sv @@
// Each request makes two passes along the row of frame cells, one cell a cycle:
// a search pass, then an update pass, each over the frames in use (1 to 8) only.
// The result register loads once the update pass is done; a stalled result delays it.
// The next request is taken the cycle after the result register loads.
// Reset clears all valid marks, ages, totals and sets frames in use to 8.
module lru_page_replacement_core
    import lrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] page_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 fault,
    output logic [FI_W-1:0]      frame_index,
    output logic [TOTAL_W-1:0]   request_total,
    output logic [TOTAL_W-1:0]   fault_total
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   fiu_reg, fiu_next;
    logic [CNT_W-1:0]   active;
    logic [IDX_W-1:0]   last;
    lrp_tok_t           head;
    lrp_tok_t           tok_q [FRAMES];
    lrp_tok_t           exit_tok;
    logic               launch_scan, scan_exit, upd_exit, out_load;

    logic [TOTAL_W-1:0] req_cnt_reg, req_cnt_next;
    logic [TOTAL_W-1:0] flt_cnt_reg, flt_cnt_next;
    logic               res_fault_reg, res_fault_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic               fault_reg;
    logic [FI_W-1:0]    frame_index_reg;
    logic [TOTAL_W-1:0] request_total_reg, fault_total_reg;

    assign pready   = 1'b1;
    assign prdata   = (paddr[ADDR_W-1] == REG_FRAMES_IN_USE) ? DATA_W'(fiu_reg) : '0;
    assign fiu_next = (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_FRAMES_IN_USE))
                      ? pwdata[CFG_W-1:0] : fiu_reg;

    always_comb
    begin
        if (fiu_reg == '0)
            active = CNT_W'(1);
        else if (32'(fiu_reg) > FRAMES)
            active = CNT_W'(FRAMES);
        else
            active = CNT_W'(fiu_reg);
    end
    assign last = IDX_W'(active - 1'b1);

    assign exit_tok    = tok_q[last];
    assign in_ready    = (state_reg == S_IDLE);
    assign launch_scan = in_valid && in_ready;
    assign scan_exit   = (state_reg == S_SCAN) && exit_tok.valid && !exit_tok.upd;
    assign upd_exit    = (state_reg == S_UPD) && exit_tok.valid && exit_tok.upd;
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        head = exit_tok;
        if (launch_scan)
        begin
            head          = '0;
            head.valid    = 1'b1;
            head.page     = page_number;
        end
        else
        begin
            head.valid = scan_exit;
            head.upd   = 1'b1;
            head.pos   = '0;
        end
    end

    lrp_cell u_cell_0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .active  (active),
        .tok_in  (head),
        .tok_out (tok_q[0])
    );

    for (genvar g = 1; g < FRAMES; g++)
    begin : g_cell
        lrp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .active  (active),
            .tok_in  (tok_q[g-1]),
            .tok_out (tok_q[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        req_cnt_next   = req_cnt_reg;
        flt_cnt_next   = flt_cnt_reg;
        res_fault_next = res_fault_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (launch_scan)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_exit)
                begin
                    state_next     = S_UPD;
                    req_cnt_next   = req_cnt_reg + 1'b1;
                    flt_cnt_next   = flt_cnt_reg + TOTAL_W'(!exit_tok.hit);
                    res_fault_next = !exit_tok.hit;
                    res_idx_next   = exit_tok.hit ? exit_tok.hit_idx : exit_tok.best_idx;
                end
            end
            S_UPD:
            begin
                if (upd_exit)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fiu_reg       <= FRAMES_IN_USE_RESET;
            req_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            req_cnt_reg   <= req_cnt_next;
            flt_cnt_reg   <= flt_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_fault_reg <= res_fault_next;
        res_idx_reg   <= res_idx_next;
        if (out_load)
        begin
            fault_reg         <= res_fault_reg;
            frame_index_reg   <= FI_W'(res_idx_reg);
            request_total_reg <= req_cnt_reg;
            fault_total_reg   <= flt_cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fault         = fault_reg;
    assign frame_index   = frame_index_reg;
    assign request_total = request_total_reg;
    assign fault_total   = fault_total_reg;

endmodule

@@ src/lrp_cell.sv @@
module lrp_cell
    import lrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] active,
    input  lrp_tok_t         tok_in,
    output lrp_tok_t         tok_out
);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 valid_reg, valid_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    lrp_tok_t             tok_reg, tok_next;
    logic [AGE_W-1:0]     aged;
    logic                 act;

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.pos   = IDX_W'(tok_in.pos + 1'b1);
        page_next      = page_reg;
        valid_next     = valid_reg;
        age_next       = age_reg;
        aged           = age_up(age_reg);
        act            = tok_in.valid && (CNT_W'(tok_in.pos) < active);
        // drop the request once it passes the last frame in use
        tok_next.valid = act;
        if (act && !tok_in.upd)
        begin
            if (!tok_in.hit && valid_reg && (page_reg == tok_in.page))
            begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = tok_in.pos;
                tok_next.hit_age = age_reg;
            end
            if (aged > tok_in.best_age)
            begin
                tok_next.best_age = aged;
                tok_next.best_idx = tok_in.pos;
            end
        end
        if (act && tok_in.upd)
        begin
            if (tok_in.hit)
            begin
                if (tok_in.pos == tok_in.hit_idx)
                    age_next = '0;
                else if (age_reg < tok_in.hit_age)
                    age_next = aged;
            end
            else
            begin
                if (tok_in.pos == tok_in.best_idx)
                begin
                    page_next  = tok_in.page;
                    valid_next = 1'b1;
                    age_next   = '0;
                end
                else
                    age_next = aged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrp_pkg::*;

    typedef struct packed {
        logic               fault;
        logic [FI_W-1:0]    frame;
        logic [TOTAL_W-1:0] req_total;
        logic [TOTAL_W-1:0] flt_total;
    } lookup_t;

    localparam logic [ADDR_W-1:0] FRAMES_IN_USE_ADDR = ADDR_W'(4 * REG_FRAMES_IN_USE);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STEADY_ITEMS = 200;
    localparam int MIX_ITEMS    = 1700;
    localparam int DRAIN_CYCLES = 2 * FRAMES + 4;
    localparam int PRINT_CAP    = 40;
    localparam int POOL_SIZE    = 12;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [PAGE_BITS-1:0] page_number = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 fault;
    logic [FI_W-1:0]      frame_index;
    logic [TOTAL_W-1:0]   request_total;
    logic [TOTAL_W-1:0]   fault_total;

    logic [PAGE_BITS-1:0] tag_of [FRAMES];
    logic                 live_of [FRAMES];
    logic [AGE_W-1:0]     age_of [FRAMES];
    logic [TOTAL_W-1:0]   refs_so_far;
    logic [TOTAL_W-1:0]   misses_so_far;
    logic [CFG_W-1:0]     frames_cfg;

    lookup_t              pending_lookups [$];
    logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];
    int                   errors = 0;
    int                   cycles = 0;
    bit                   calm = 1'b0;

    lru_page_replacement_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fault         (fault),
        .frame_index   (frame_index),
        .request_total (request_total),
        .fault_total   (fault_total)
    );

    always #5 clk = ~clk;

    function automatic int active_span();
        if (frames_cfg == 0)
        begin
            return 1;
        end
        if (frames_cfg > FRAMES)
        begin
            return FRAMES;
        end
        return int'(frames_cfg);
    endfunction

    function automatic lookup_t lru_lookup(input logic [PAGE_BITS-1:0] page);
        lookup_t          r;
        int               span;
        int               used;
        bit               hit;
        logic [AGE_W-1:0] pivot;
        span = active_span();
        used = 0;
        hit  = 1'b0;
        refs_so_far = refs_so_far + 1'b1;
        for (int i = 0; i < span && !hit; i++)
        begin
            if (live_of[i] && tag_of[i] == page)
            begin
                hit  = 1'b1;
                used = i;
            end
        end
        if (hit)
        begin
            pivot = age_of[used];
            for (int i = 0; i < span; i++)
            begin
                if (age_of[i] < pivot && age_of[i] != AGE_MAX)
                begin
                    age_of[i] = age_of[i] + 1'b1;
                end
            end
            age_of[used] = '0;
        end
        else
        begin
            misses_so_far = misses_so_far + 1'b1;
            for (int i = 0; i < span; i++)
            begin
                if (age_of[i] != AGE_MAX)
                begin
                    age_of[i] = age_of[i] + 1'b1;
                end
            end
            pivot = age_of[0];
            for (int i = 1; i < span; i++)
            begin
                if (age_of[i] > pivot)
                begin
                    pivot = age_of[i];
                    used  = i;
                end
            end
            tag_of[used]  = page;
            live_of[used] = 1'b1;
            age_of[used]  = '0;
        end
        r.fault     = !hit;
        r.frame     = FI_W'(used);
        r.req_total = refs_so_far;
        r.flt_total = misses_so_far;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                 input logic [TOTAL_W-1:0] want);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        end
    endtask

    // hold the request until it is taken, then predict its result
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int gap;
        if (!calm && $urandom_range(99) < 11)
        begin
            gap = $urandom_range(1, 2 * FRAMES + 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        do @(posedge clk); while (!in_ready);
        pending_lookups.push_back(lru_lookup(page));
    endtask

    task automatic hold_requests();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_lookups.size() != 0 || !in_ready);
    endtask

    task automatic write_frames_cfg(input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] word;
        hold_requests();
        word = $urandom;
        word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAMES_IN_USE_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        frames_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CFG_W-1:0] !== value)
        begin
            flag_mismatch("frames_in_use readback", TOTAL_W'(prdata[CFG_W-1:0]),
                          TOTAL_W'(value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        lookup_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                flag_mismatch("result with no request waiting", request_total, '0);
            end
            else
            begin
                due = pending_lookups.pop_front();
                if (fault !== due.fault)
                begin
                    flag_mismatch("fault", TOTAL_W'(fault), TOTAL_W'(due.fault));
                end
                if (frame_index !== due.frame)
                begin
                    flag_mismatch("frame_index", TOTAL_W'(frame_index), TOTAL_W'(due.frame));
                end
                if (request_total !== due.req_total)
                begin
                    flag_mismatch("request_total", request_total, due.req_total);
                end
                if (fault_total !== due.flt_total)
                begin
                    flag_mismatch("fault_total", fault_total, due.flt_total);
                end
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_basic_fill();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h1234);
        send_page(16'h00FF);
        send_page(16'h0000);
        send_page(16'hAAAA);
        send_page(16'h1234);
        send_page(16'h4321);
    endtask

    task automatic test_frame_count_limits();
        write_frames_cfg(4'd0);
        send_page(16'hFFFF);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        write_frames_cfg(4'd15);
        send_page(16'hAAAA);
        write_frames_cfg(4'd9);
        send_page(16'h7777);
        write_frames_cfg(4'd1);
        send_page(16'h7777);
    endtask

    // park a copy of a high frame's page in a low frame, then widen again
    task automatic test_shadowed_duplicates();
        logic [PAGE_BITS-1:0] shadow;
        write_frames_cfg(CFG_W'(FRAMES));
        shadow = live_of[FRAMES-1] ? tag_of[FRAMES-1] : 16'h5555;
        send_page(shadow);
        write_frames_cfg(4'd2);
        send_page(shadow);
        write_frames_cfg(CFG_W'(FRAMES));
        send_page(shadow);
        send_page(shadow);
    endtask

    task automatic pick_and_send();
        int reach;
        reach = active_span() + 3;
        if (reach > POOL_SIZE)
        begin
            reach = POOL_SIZE;
        end
        if ($urandom_range(99) < 88)
        begin
            send_page(page_pool[$urandom_range(reach - 1)]);
        end
        else
        begin
            send_page(PAGE_BITS'($urandom));
        end
    endtask

    task automatic test_steady_stream();
        foreach (page_pool[i])
        begin
            page_pool[i] = PAGE_BITS'($urandom);
        end
        calm = 1'b1;
        write_frames_cfg(4'd4);
        repeat (STEADY_ITEMS) pick_and_send();
        hold_requests();
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        int               sent;
        int               phase;
        int               batch;
        logic [CFG_W-1:0] setting;
        sent  = 0;
        phase = 0;
        while (sent < MIX_ITEMS)
        begin
            if (phase == 0)
            begin
                setting = 4'd1;
            end
            else if (phase == 1)
            begin
                setting = CFG_W'(FRAMES);
            end
            else if ($urandom_range(9) == 0)
            begin
                setting = $urandom_range(1) ? CFG_W'($urandom_range(15, FRAMES + 1)) : '0;
            end
            else
            begin
                setting = CFG_W'($urandom_range(FRAMES, 1));
            end
            write_frames_cfg(setting);
            repeat ($urandom_range(3)) page_pool[$urandom_range(POOL_SIZE - 1)] =
                PAGE_BITS'($urandom);
            batch = $urandom_range(160, 40);
            for (int k = 0; k < batch; k++)
            begin
                if (phase == 2 && k == batch / 2)
                begin
                    hold_requests();
                end
                pick_and_send();
            end
            sent += batch;
            phase++;
        end
    endtask

    initial
    begin
        foreach (tag_of[i])
        begin
            tag_of[i]  = '0;
            live_of[i] = 1'b0;
            age_of[i]  = '0;
        end
        refs_so_far   = '0;
        misses_so_far = '0;
        frames_cfg    = FRAMES_IN_USE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_fill();
        test_frame_count_limits();
        test_shadowed_duplicates();
        test_steady_stream();
        test_random_mix();

        hold_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/lrp_pkg.sv
src/lrp_cell.sv
src/lru_page_replacement_core.sv
tb/sv/tb.sv
